// ===== hdl/i2cm_pkg.sv =====
// Shared types, codes and sizes for the I2C register-access master.
`default_nettype none

package i2cm_pkg;

   // Write buffer depth and the widths that follow from it.
   localparam int BUF_DEPTH = 16;
   localparam int PTR_W     = (BUF_DEPTH > 1) ? $clog2(BUF_DEPTH) : 1;
   localparam int FILL_W    = $clog2(BUF_DEPTH + 1);

   localparam int COUNT_W   = 5;
   localparam int TIMEOUT_W = 16;
   localparam int PHASE_W   = 10;
   localparam int BITCNT_W  = 4;
   localparam int CSR_IDX_W = 1;
   localparam int CSR_DAT_W = 16;

   localparam logic [TIMEOUT_W-1:0] ACK_TIMEOUT_RST = 16'd5000;
   localparam logic [PHASE_W-1:0]   PHASE_TICKS_RST = 10'd1;
   localparam logic [BITCNT_W-1:0]  BITS_PER_BYTE   = 4'd8;

   // Request modes.
   localparam logic [1:0] MODE_TICK  = 2'd0;
   localparam logic [1:0] MODE_LOAD  = 2'd1;
   localparam logic [1:0] MODE_WRITE = 2'd2;
   localparam logic [1:0] MODE_READ  = 2'd3;

   // Configuration register indexes.
   localparam logic [CSR_IDX_W-1:0] CSR_ACK_TIMEOUT = 1'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_PHASE_TICKS = 1'd1;

   typedef enum logic [4:0] {
      ST_IDLE, ST_START_A, ST_START_B, ST_START_C, ST_START_D,
      ST_TX_LOW, ST_TX_DATA, ST_TX_HIGH, ST_TX_HOLD,
      ST_ACK_REL, ST_ACK_RISE, ST_ACK_CHK,
      ST_RX_LOW, ST_RX_HIGH, ST_RX_SAMP,
      ST_RA_DRIVE, ST_RA_HIGH, ST_RA_LOW,
      ST_STOP_A, ST_STOP_B, ST_STOP_C, ST_STOP_D
   } state_type;

   // Which byte of the transfer is on the wire.
   typedef enum logic [1:0] {
      KIND_AW, KIND_REG, KIND_AR, KIND_DATA
   } kind_type;

   typedef struct packed {
      logic       scl_release;
      logic       sda_release;
      logic       busy_res;
      logic [7:0] read_byte;
      logic       read_valid;
      logic       read_last;
      logic       done_res;
      logic       status;
   } rsp_type;

endpackage

`default_nettype wire

// ===== hdl/i2c_register_access_master.sv =====
// Top level of the I2C register-access master: sequencer, write buffer and result buffering.
//
// Usage: every request beat on req_* carries a mode. A tick (mode 0) advances the bus
// sequencer by one step; phase_ticks ticks make one bus phase, and while an ACK is awaited
// every tick samples req_sda_in. Mode 1 appends req_data_byte to the 16-entry write buffer
// while idle. Modes 2 and 3 start a register write or read while idle; commands that arrive
// while busy are ignored. Every request beat yields exactly one response beat on rsp_* with
// the line levels, busy flag, any received byte and the done/status flags.
// Configuration writes on csr_* (index 0 ack_timeout, index 1 phase_ticks) are always ready
// and are meant to be issued only while the block is idle.
// One request is taken every cycle while req_ready is high. The response is registered:
// the sequencer step and the register file update lie between the request handshake and
// the response register.
// A two-entry response buffer (output register plus skid register) lets a request be taken
// while one response waits; when both are full, req_ready drops until rsp_ready drains one.
// Synchronous reset returns the bus lines to released, the sequencer to idle, empties the
// write buffer and the response buffer, and loads the default configuration.
`default_nettype none

module i2c_register_access_master (
   input  wire logic                           clock,
   input  wire logic                           reset,
   input  wire logic                           req_valid,
   output      logic                           req_ready,
   input  wire logic [1:0]                     req_mode,
   input  wire logic                           req_sda_in,
   input  wire logic [6:0]                     req_slave_addr,
   input  wire logic [7:0]                     req_reg_addr,
   input  wire logic [7:0]                     req_data_byte,
   input  wire logic [i2cm_pkg::COUNT_W-1:0]   req_byte_count,
   output      logic                           rsp_valid,
   input  wire logic                           rsp_ready,
   output      logic                           rsp_scl_release,
   output      logic                           rsp_sda_release,
   output      logic                           rsp_busy_res,
   output      logic [7:0]                     rsp_read_byte,
   output      logic                           rsp_read_valid,
   output      logic                           rsp_read_last,
   output      logic                           rsp_done_res,
   output      logic                           rsp_status,
   input  wire logic                           csr_valid,
   output      logic                           csr_ready,
   input  wire logic [i2cm_pkg::CSR_IDX_W-1:0] csr_index,
   input  wire logic [i2cm_pkg::CSR_DAT_W-1:0] csr_data
);
   import i2cm_pkg::*;

   // Configuration.
   logic [TIMEOUT_W-1:0] ack_timeout_ff;
   logic [PHASE_W-1:0]   phase_ticks_ff;

   // Sequencer state.
   state_type            state_ff, state_in;
   kind_type             kind_ff, kind_in;
   logic [BITCNT_W-1:0]  bit_count_ff, bit_count_in;
   logic [7:0]           shift_ff, shift_in;
   logic [COUNT_W-1:0]   bytes_left_ff, bytes_left_in;
   logic [TIMEOUT_W-1:0] ack_wait_ff, ack_wait_in;
   logic [PHASE_W-1:0]   phase_count_ff, phase_count_in;
   logic [FILL_W-1:0]    store_fill_ff, store_fill_in;
   logic [FILL_W-1:0]    read_ptr_ff, read_ptr_in;
   logic [6:0]           target_addr_ff, target_addr_in;
   logic [7:0]           target_reg_ff, target_reg_in;
   logic                 read_mode_ff, read_mode_in;
   logic                 failed_ff, failed_in;
   logic                 scl_ff, scl_in;
   logic                 sda_ff, sda_in;

   logic [7:0]           write_store_ff [BUF_DEPTH];
   logic                 store_we;

   // Response buffering.
   rsp_type              result;
   rsp_type              out_ff, out_in, skid_ff, skid_in;
   logic                 out_valid_ff, out_valid_in, skid_valid_ff, skid_valid_in;

   // Shared decode.
   logic                 accept, take_out;
   logic                 is_idle, cmd_start, cmd_load, step, in_ack;
   logic [TIMEOUT_W-1:0] ack_dec;
   logic [PHASE_W-1:0]   phase_eff, phase_inc;
   logic                 fire;
   logic [BITCNT_W-1:0]  bit_inc;
   logic                 byte_end;
   logic                 have_data;
   logic [COUNT_W-1:0]   bytes_dec;
   logic [7:0]           rx_shift;
   logic [7:0]           store_rd;

   assign accept    = req_valid && req_ready;
   assign take_out  = out_valid_ff && rsp_ready;
   assign is_idle   = (state_ff == ST_IDLE);
   assign cmd_start = accept && is_idle && (req_mode inside {MODE_WRITE, MODE_READ});
   assign cmd_load  = accept && is_idle && (req_mode == MODE_LOAD);
   assign step      = accept && !is_idle && (req_mode == MODE_TICK);
   assign in_ack    = (state_ff == ST_ACK_CHK);
   assign ack_dec   = ack_wait_ff - 1'b1;
   assign phase_eff = (phase_ticks_ff == '0) ? PHASE_W'(1) : phase_ticks_ff;
   assign phase_inc = phase_count_ff + 1'b1;
   assign fire      = step && !in_ack && (phase_inc >= phase_eff);
   assign bit_inc   = bit_count_ff + 1'b1;
   assign byte_end  = (bit_inc >= BITS_PER_BYTE);
   assign have_data = (bytes_left_ff != '0) && (int'(read_ptr_ff) < BUF_DEPTH);
   assign bytes_dec = bytes_left_ff - 1'b1;
   assign rx_shift  = {shift_ff[6:0], req_sda_in};
   assign store_rd  = write_store_ff[read_ptr_ff[PTR_W-1:0]];

   // Next state of the bus sequencer.
   always_comb begin
      state_in = state_ff;
      if (cmd_start) begin
         state_in = ST_START_A;
      end else if (step && in_ack) begin
         if (!req_sda_in) begin
            case (kind_ff)
               KIND_AW:  state_in = ST_TX_DATA;
               KIND_REG: begin
                  if (read_mode_ff)   state_in = ST_START_A;
                  else if (have_data) state_in = ST_TX_DATA;
                  else                state_in = ST_STOP_A;
               end
               KIND_AR:  state_in = (bytes_left_ff != '0) ? ST_RX_LOW : ST_STOP_A;
               default:  state_in = have_data ? ST_TX_DATA : ST_STOP_A;
            endcase
         end else if (ack_dec == '0) begin
            state_in = ST_STOP_A;
         end
      end else if (fire) begin
         case (state_ff)
            ST_START_A:  state_in = ST_START_B;
            ST_START_B:  state_in = ST_START_C;
            ST_START_C:  state_in = ST_START_D;
            ST_START_D:  state_in = ST_TX_LOW;
            ST_TX_LOW:   state_in = ST_TX_DATA;
            ST_TX_DATA:  state_in = ST_TX_HIGH;
            ST_TX_HIGH:  state_in = ST_TX_HOLD;
            ST_TX_HOLD:  state_in = byte_end ? ST_ACK_REL : ST_TX_DATA;
            ST_ACK_REL:  state_in = ST_ACK_RISE;
            ST_ACK_RISE: state_in = ST_ACK_CHK;
            ST_RX_LOW:   state_in = ST_RX_HIGH;
            ST_RX_HIGH:  state_in = ST_RX_SAMP;
            ST_RX_SAMP:  state_in = byte_end ? ST_RA_DRIVE : ST_RX_HIGH;
            ST_RA_DRIVE: state_in = ST_RA_HIGH;
            ST_RA_HIGH:  state_in = ST_RA_LOW;
            ST_RA_LOW:   state_in = (bytes_left_ff != '0) ? ST_RX_LOW : ST_STOP_A;
            ST_STOP_A:   state_in = ST_STOP_B;
            ST_STOP_B:   state_in = ST_STOP_C;
            ST_STOP_C:   state_in = ST_STOP_D;
            default:     state_in = ST_IDLE;
         endcase
      end
   end

   // Datapath updates and the response of this beat.
   always_comb begin
      kind_in        = kind_ff;
      bit_count_in   = bit_count_ff;
      shift_in       = shift_ff;
      bytes_left_in  = bytes_left_ff;
      ack_wait_in    = ack_wait_ff;
      phase_count_in = phase_count_ff;
      store_fill_in  = store_fill_ff;
      read_ptr_in    = read_ptr_ff;
      target_addr_in = target_addr_ff;
      target_reg_in  = target_reg_ff;
      read_mode_in   = read_mode_ff;
      failed_in      = failed_ff;
      scl_in         = scl_ff;
      sda_in         = sda_ff;
      store_we       = 1'b0;
      result         = '0;

      if (cmd_load) begin
         if (int'(store_fill_ff) < BUF_DEPTH) begin
            store_we      = 1'b1;
            store_fill_in = store_fill_ff + 1'b1;
         end
      end else if (cmd_start) begin
         target_addr_in = req_slave_addr;
         target_reg_in  = req_reg_addr;
         read_mode_in   = (req_mode == MODE_READ);
         kind_in        = KIND_AW;
         failed_in      = 1'b0;
         phase_count_in = '0;
         bit_count_in   = '0;
         read_ptr_in    = '0;
         if (req_mode == MODE_READ || int'(req_byte_count) < int'(store_fill_ff)) begin
            bytes_left_in = req_byte_count;
         end else begin
            bytes_left_in = COUNT_W'(store_fill_ff);
         end
      end else if (step && in_ack) begin
         if (!req_sda_in) begin
            scl_in         = 1'b0;
            phase_count_in = '0;
            bit_count_in   = '0;
            case (kind_ff)
               KIND_AW: begin
                  shift_in = target_reg_ff;
                  kind_in  = KIND_REG;
               end
               KIND_AR: begin
                  if (bytes_left_ff != '0) shift_in = '0;
               end
               default: begin
                  if (kind_ff == KIND_REG && read_mode_ff) begin
                     kind_in = KIND_AR;
                  end else if (have_data) begin
                     shift_in      = store_rd;
                     read_ptr_in   = read_ptr_ff + 1'b1;
                     bytes_left_in = bytes_dec;
                     kind_in       = KIND_DATA;
                  end
               end
            endcase
         end else begin
            ack_wait_in = ack_dec;
            if (ack_dec == '0) begin
               failed_in      = 1'b1;
               phase_count_in = '0;
            end
         end
      end else if (step) begin
         phase_count_in = fire ? '0 : phase_inc;
         if (fire) begin
            case (state_ff)
               ST_START_A:  sda_in = 1'b1;
               ST_START_B:  scl_in = 1'b1;
               ST_START_C:  sda_in = 1'b0;
               ST_START_D: begin
                  shift_in     = {target_addr_ff, kind_ff == KIND_AR};
                  bit_count_in = '0;
               end
               ST_TX_LOW:   scl_in = 1'b0;
               ST_TX_DATA: begin
                  sda_in   = shift_ff[7];
                  shift_in = {shift_ff[6:0], 1'b0};
               end
               ST_TX_HIGH:  scl_in = 1'b1;
               ST_TX_HOLD: begin
                  scl_in       = 1'b0;
                  bit_count_in = bit_inc;
               end
               ST_ACK_REL:  sda_in = 1'b1;
               ST_ACK_RISE: begin
                  scl_in      = 1'b1;
                  ack_wait_in = ack_timeout_ff;
               end
               ST_RX_LOW: begin
                  scl_in = 1'b0;
                  sda_in = 1'b1;
               end
               ST_RX_HIGH:  scl_in = 1'b1;
               ST_RX_SAMP: begin
                  shift_in     = rx_shift;
                  bit_count_in = bit_inc;
                  scl_in       = 1'b0;
                  if (byte_end) begin
                     bytes_left_in     = bytes_dec;
                     result.read_valid = 1'b1;
                     result.read_byte  = rx_shift;
                     result.read_last  = (bytes_dec == '0);
                  end
               end
               ST_RA_DRIVE: sda_in = (bytes_left_ff == '0);
               ST_RA_HIGH:  scl_in = 1'b1;
               ST_RA_LOW: begin
                  scl_in = 1'b0;
                  if (bytes_left_ff != '0) begin
                     shift_in     = '0;
                     bit_count_in = '0;
                  end
               end
               ST_STOP_A:   scl_in = 1'b0;
               ST_STOP_B:   sda_in = 1'b0;
               ST_STOP_C:   scl_in = 1'b1;
               ST_STOP_D: begin
                  sda_in          = 1'b1;
                  result.done_res = 1'b1;
                  result.status   = failed_ff;
                  if (!read_mode_ff) store_fill_in = '0;
                  read_ptr_in     = '0;
               end
               default: ;
            endcase
         end
      end

      result.scl_release = scl_in;
      result.sda_release = sda_in;
      result.busy_res    = (state_in != ST_IDLE);
   end

   // A new response goes to the output register when it is free or draining,
   // otherwise it parks in the skid register.
   always_comb begin
      out_in        = out_ff;
      skid_in       = skid_ff;
      out_valid_in  = out_valid_ff;
      skid_valid_in = skid_valid_ff;
      if (accept) begin
         if (!out_valid_ff || take_out) begin
            out_in       = result;
            out_valid_in = 1'b1;
         end else begin
            skid_in       = result;
            skid_valid_in = 1'b1;
         end
      end else if (take_out) begin
         if (skid_valid_ff) begin
            out_in        = skid_ff;
            skid_valid_in = 1'b0;
         end else begin
            out_valid_in = 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         ack_timeout_ff <= ACK_TIMEOUT_RST;
         phase_ticks_ff <= PHASE_TICKS_RST;
         state_ff       <= ST_IDLE;
         kind_ff        <= KIND_AW;
         bit_count_ff   <= '0;
         shift_ff       <= '0;
         bytes_left_ff  <= '0;
         ack_wait_ff    <= '0;
         phase_count_ff <= '0;
         store_fill_ff  <= '0;
         read_ptr_ff    <= '0;
         target_addr_ff <= '0;
         target_reg_ff  <= '0;
         read_mode_ff   <= 1'b0;
         failed_ff      <= 1'b0;
         scl_ff         <= 1'b1;
         sda_ff         <= 1'b1;
         out_valid_ff   <= 1'b0;
         skid_valid_ff  <= 1'b0;
      end else begin
         if (csr_valid && csr_ready) begin
            case (csr_index)
               CSR_ACK_TIMEOUT: ack_timeout_ff <= csr_data;
               CSR_PHASE_TICKS: phase_ticks_ff <= csr_data[PHASE_W-1:0];
               default: ;
            endcase
         end
         state_ff       <= state_in;
         kind_ff        <= kind_in;
         bit_count_ff   <= bit_count_in;
         shift_ff       <= shift_in;
         bytes_left_ff  <= bytes_left_in;
         ack_wait_ff    <= ack_wait_in;
         phase_count_ff <= phase_count_in;
         store_fill_ff  <= store_fill_in;
         read_ptr_ff    <= read_ptr_in;
         target_addr_ff <= target_addr_in;
         target_reg_ff  <= target_reg_in;
         read_mode_ff   <= read_mode_in;
         failed_ff      <= failed_in;
         scl_ff         <= scl_in;
         sda_ff         <= sda_in;
         out_valid_ff   <= out_valid_in;
         skid_valid_ff  <= skid_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      out_ff  <= out_in;
      skid_ff <= skid_in;
      if (store_we) begin
         write_store_ff[store_fill_ff[PTR_W-1:0]] <= req_data_byte;
      end
   end

   assign req_ready       = !skid_valid_ff;
   assign csr_ready       = 1'b1;
   assign rsp_valid       = out_valid_ff;
   assign rsp_scl_release = out_ff.scl_release;
   assign rsp_sda_release = out_ff.sda_release;
   assign rsp_busy_res    = out_ff.busy_res;
   assign rsp_read_byte   = out_ff.read_byte;
   assign rsp_read_valid  = out_ff.read_valid;
   assign rsp_read_last   = out_ff.read_last;
   assign rsp_done_res    = out_ff.done_res;
   assign rsp_status      = out_ff.status;

   // The skid register is only filled behind a waiting output register.
   a_skid_behind_out: assert property (@(posedge clock) disable iff (reset)
      skid_valid_ff |-> out_valid_ff)
      else $error("skid register holds a beat while the output register is empty");

   a_fill_bound: assert property (@(posedge clock) disable iff (reset)
      int'(store_fill_ff) <= BUF_DEPTH)
      else $error("write buffer fill count exceeds its depth");

   // SCL is released for the whole ACK wait.
   a_scl_high_in_ack: assert property (@(posedge clock) disable iff (reset)
      in_ack |-> scl_ff)
      else $error("SCL pulled low while waiting for ACK");

   a_done_not_busy: assert property (@(posedge clock) disable iff (reset)
      out_valid_ff && out_ff.done_res |-> !out_ff.busy_res && !out_ff.read_valid)
      else $error("done reported together with busy or a received byte");

   a_done_after_stop: assert property (@(posedge clock) disable iff (reset)
      accept && result.done_res |-> state_ff == ST_STOP_D)
      else $error("done raised outside the last stop phase");

endmodule

`default_nettype wire

// ===== verif/testbench.sv =====
// Self-checking testbench: random I2C register transfers against a cycle-free bus predictor.
`timescale 1ns / 100ps

module testbench;
   import i2cm_pkg::*;

   // One request beat as the driver presents it.
   typedef struct packed {
      logic [1:0]         mode;
      logic               sda;
      logic [6:0]         saddr;
      logic [7:0]         raddr;
      logic [7:0]         data;
      logic [COUNT_W-1:0] count;
   } req_item_type;

   // Everything the sequencer remembers between request beats.
   typedef struct packed {
      state_type                 st;
      kind_type                  kind;
      logic                      failed;
      logic [3:0]                bit_cnt;
      logic [7:0]                shifter;
      logic [4:0]                left;
      logic [15:0]               ack_left;
      logic [9:0]                phase_cnt;
      logic [BUF_DEPTH-1:0][7:0] store;
      logic [FILL_W-1:0]         fill;
      logic [FILL_W-1:0]         rd_ptr;
      logic [6:0]                addr;
      logic [7:0]                regaddr;
      logic                      is_read;
      logic                      scl;
      logic                      sda;
   } bus_model_type;

   typedef enum int {SLAVE_ACKS, SLAVE_SLOW, SLAVE_ABSENT} slave_kind_type;
   typedef enum int {IDLE_NONE, IDLE_LIGHT, IDLE_FULL} idle_kind_type;

   logic clock = 1'b0;
   logic reset = 1'b1;

   logic               req_valid = 1'b0;
   logic               req_ready;
   logic [1:0]         req_mode = MODE_TICK;
   logic               req_sda_in = 1'b1;
   logic [6:0]         req_slave_addr = '0;
   logic [7:0]         req_reg_addr = '0;
   logic [7:0]         req_data_byte = '0;
   logic [COUNT_W-1:0] req_byte_count = '0;
   logic               rsp_valid;
   logic               rsp_ready = 1'b0;
   logic               rsp_scl_release;
   logic               rsp_sda_release;
   logic               rsp_busy_res;
   logic [7:0]         rsp_read_byte;
   logic               rsp_read_valid;
   logic               rsp_read_last;
   logic               rsp_done_res;
   logic               rsp_status;
   logic                 csr_valid = 1'b0;
   logic                 csr_ready;
   logic [CSR_IDX_W-1:0] csr_index = CSR_ACK_TIMEOUT;
   logic [CSR_DAT_W-1:0] csr_data = '0;

   i2c_register_access_master dut (
      .clock          (clock),
      .reset          (reset),
      .req_valid      (req_valid),
      .req_ready      (req_ready),
      .req_mode       (req_mode),
      .req_sda_in     (req_sda_in),
      .req_slave_addr (req_slave_addr),
      .req_reg_addr   (req_reg_addr),
      .req_data_byte  (req_data_byte),
      .req_byte_count (req_byte_count),
      .rsp_valid      (rsp_valid),
      .rsp_ready      (rsp_ready),
      .rsp_scl_release(rsp_scl_release),
      .rsp_sda_release(rsp_sda_release),
      .rsp_busy_res   (rsp_busy_res),
      .rsp_read_byte  (rsp_read_byte),
      .rsp_read_valid (rsp_read_valid),
      .rsp_read_last  (rsp_read_last),
      .rsp_done_res   (rsp_done_res),
      .rsp_status     (rsp_status),
      .csr_valid      (csr_valid),
      .csr_ready      (csr_ready),
      .csr_index      (csr_index),
      .csr_data       (csr_data)
   );

   always begin
      #6 clock = 1'b1;
      #6 clock = 1'b0;
   end

   logic [TIMEOUT_W-1:0] cfg_ack_timeout = ACK_TIMEOUT_RST;
   logic [PHASE_W-1:0]   cfg_phase_ticks = PHASE_TICKS_RST;

   req_item_type  pending_req[$];
   rsp_type       expected_rsp[$];
   bus_model_type live;
   bus_model_type plan;
   idle_kind_type idle_style = IDLE_FULL;
   int hold_asks = 0;
   int useful_items = 0;
   int mismatches = 0;
   int beats_sent = 0;
   int beats_checked = 0;
   int bytes_read = 0;
   int transfers_done = 0;
   int timeouts_seen = 0;

   function automatic bus_model_type fresh_model();
      bus_model_type m;
      m = '0;
      m.st = ST_IDLE;
      m.kind = KIND_AW;
      m.scl = 1'b1;
      m.sda = 1'b1;
      return m;
   endfunction

   // Loads the next buffered byte for transmission, or heads for STOP when none is left.
   function automatic void next_write_byte(inout bus_model_type m);
      if (m.left != 0 && m.rd_ptr < BUF_DEPTH) begin
         m.shifter = m.store[m.rd_ptr[PTR_W-1:0]];
         m.rd_ptr = m.rd_ptr + 1'b1;
         m.left = m.left - 1'b1;
         m.kind = KIND_DATA;
         m.bit_cnt = '0;
         m.st = ST_TX_DATA;
      end else begin
         m.st = ST_STOP_A;
         m.phase_cnt = '0;
      end
   endfunction

   function automatic void step_bus(inout bus_model_type m, input req_item_type it,
                                    output rsp_type r);
      logic [9:0] span;
      r = '0;
      if (m.st == ST_IDLE) begin
         if (it.mode == MODE_LOAD) begin
            if (m.fill < BUF_DEPTH) begin
               m.store[m.fill[PTR_W-1:0]] = it.data;
               m.fill = m.fill + 1'b1;
            end
         end else if (it.mode == MODE_WRITE || it.mode == MODE_READ) begin
            m.addr = it.saddr;
            m.regaddr = it.raddr;
            m.is_read = (it.mode == MODE_READ);
            m.kind = KIND_AW;
            m.failed = 1'b0;
            m.phase_cnt = '0;
            m.bit_cnt = '0;
            m.rd_ptr = '0;
            if (m.is_read || it.count < m.fill) m.left = it.count;
            else m.left = COUNT_W'(m.fill);
            m.st = ST_START_A;
         end
      end else if (it.mode == MODE_TICK) begin
         if (m.st == ST_ACK_CHK) begin
            // The ACK window looks at SDA on every tick, not once per phase.
            if (!it.sda) begin
               m.scl = 1'b0;
               m.phase_cnt = '0;
               m.bit_cnt = '0;
               case (m.kind)
                  KIND_AW: begin
                     m.shifter = m.regaddr;
                     m.kind = KIND_REG;
                     m.st = ST_TX_DATA;
                  end
                  KIND_REG: begin
                     if (m.is_read) begin
                        m.kind = KIND_AR;
                        m.st = ST_START_A;
                     end else begin
                        next_write_byte(m);
                     end
                  end
                  KIND_AR: begin
                     if (m.left != 0) begin
                        m.shifter = '0;
                        m.st = ST_RX_LOW;
                     end else begin
                        m.st = ST_STOP_A;
                     end
                  end
                  default: next_write_byte(m);
               endcase
            end else begin
               m.ack_left = m.ack_left - 1'b1;
               if (m.ack_left == 0) begin
                  m.failed = 1'b1;
                  m.st = ST_STOP_A;
                  m.phase_cnt = '0;
               end
            end
         end else begin
            span = (cfg_phase_ticks == 0) ? 10'd1 : cfg_phase_ticks;
            m.phase_cnt = m.phase_cnt + 1'b1;
            if (m.phase_cnt >= span) begin
               m.phase_cnt = '0;
               case (m.st)
                  ST_START_A: begin m.sda = 1'b1; m.st = ST_START_B; end
                  ST_START_B: begin m.scl = 1'b1; m.st = ST_START_C; end
                  ST_START_C: begin m.sda = 1'b0; m.st = ST_START_D; end
                  ST_START_D: begin
                     m.shifter = {m.addr, m.kind == KIND_AR};
                     m.bit_cnt = '0;
                     m.st = ST_TX_LOW;
                  end
                  ST_TX_LOW: begin m.scl = 1'b0; m.st = ST_TX_DATA; end
                  ST_TX_DATA: begin
                     m.sda = m.shifter[7];
                     m.shifter = {m.shifter[6:0], 1'b0};
                     m.st = ST_TX_HIGH;
                  end
                  ST_TX_HIGH: begin m.scl = 1'b1; m.st = ST_TX_HOLD; end
                  ST_TX_HOLD: begin
                     m.scl = 1'b0;
                     m.bit_cnt = m.bit_cnt + 1'b1;
                     if (m.bit_cnt >= 8) m.st = ST_ACK_REL;
                     else m.st = ST_TX_DATA;
                  end
                  ST_ACK_REL: begin m.sda = 1'b1; m.st = ST_ACK_RISE; end
                  ST_ACK_RISE: begin
                     m.scl = 1'b1;
                     m.ack_left = cfg_ack_timeout;
                     m.st = ST_ACK_CHK;
                  end
                  ST_RX_LOW: begin m.scl = 1'b0; m.sda = 1'b1; m.st = ST_RX_HIGH; end
                  ST_RX_HIGH: begin m.scl = 1'b1; m.st = ST_RX_SAMP; end
                  ST_RX_SAMP: begin
                     m.shifter = {m.shifter[6:0], it.sda};
                     m.bit_cnt = m.bit_cnt + 1'b1;
                     m.scl = 1'b0;
                     if (m.bit_cnt >= 8) begin
                        m.left = m.left - 1'b1;
                        r.read_valid = 1'b1;
                        r.read_byte = m.shifter;
                        r.read_last = (m.left == 0);
                        m.st = ST_RA_DRIVE;
                     end else begin
                        m.st = ST_RX_HIGH;
                     end
                  end
                  ST_RA_DRIVE: begin m.sda = (m.left == 0); m.st = ST_RA_HIGH; end
                  ST_RA_HIGH: begin m.scl = 1'b1; m.st = ST_RA_LOW; end
                  ST_RA_LOW: begin
                     m.scl = 1'b0;
                     if (m.left != 0) begin
                        m.shifter = '0;
                        m.bit_cnt = '0;
                        m.st = ST_RX_LOW;
                     end else begin
                        m.st = ST_STOP_A;
                     end
                  end
                  ST_STOP_A: begin m.scl = 1'b0; m.st = ST_STOP_B; end
                  ST_STOP_B: begin m.sda = 1'b0; m.st = ST_STOP_C; end
                  ST_STOP_C: begin m.scl = 1'b1; m.st = ST_STOP_D; end
                  ST_STOP_D: begin
                     m.sda = 1'b1;
                     r.done_res = 1'b1;
                     r.status = m.failed;
                     if (!m.is_read) m.fill = '0;
                     m.rd_ptr = '0;
                     m.st = ST_IDLE;
                  end
                  default: m.st = ST_IDLE;
               endcase
            end
         end
      end
      r.scl_release = m.scl;
      r.sda_release = m.sda;
      r.busy_res = (m.st != ST_IDLE);
   endfunction

   function automatic int idle_draw();
      case (idle_style)
         IDLE_NONE: return 0;
         IDLE_LIGHT: return ($urandom_range(0, 3) == 0) ? int'($urandom_range(0, 3)) : 0;
         default: return int'($urandom_range(0, 17));
      endcase
   endfunction

   function automatic req_item_type any_item(input logic [1:0] mode);
      req_item_type it;
      it.mode = mode;
      it.sda = 1'($urandom_range(0, 1));
      it.saddr = 7'($urandom_range(0, 127));
      it.raddr = 8'($urandom_range(0, 255));
      it.data = 8'($urandom_range(0, 255));
      it.count = COUNT_W'($urandom_range(0, 31));
      return it;
   endfunction

   // Queues a beat and runs it through the planning copy so later choices see the bus state.
   task automatic offer(input req_item_type it);
      rsp_type unused;
      if ((plan.st == ST_IDLE) != (it.mode == MODE_TICK)) useful_items++;
      step_bus(plan, it, unused);
      pending_req.push_back(it);
   endtask

   task automatic finish_transfer(input slave_kind_type slave, input bit noisy);
      req_item_type it;
      while (plan.st != ST_IDLE) begin
         if (noisy && $urandom_range(0, 39) == 0) offer(any_item(2'($urandom_range(1, 3))));
         it = any_item(MODE_TICK);
         if (plan.st == ST_ACK_CHK) begin
            case (slave)
               SLAVE_ACKS: it.sda = ($urandom_range(0, 3) == 0);
               SLAVE_SLOW: it.sda = ($urandom_range(0, 19) != 0);
               default: it.sda = 1'b1;
            endcase
         end
         offer(it);
      end
   endtask

   task automatic random_transfer();
      req_item_type it;
      int n;
      int pick;
      n = ($urandom_range(0, 4) == 0) ? $urandom_range(14, 18) : $urandom_range(0, 4);
      repeat (n) offer(any_item(MODE_LOAD));
      if ($urandom_range(0, 9) == 0) offer(any_item(MODE_TICK));
      it = any_item(($urandom_range(0, 2) == 0) ? MODE_READ : MODE_WRITE);
      pick = $urandom_range(0, 99);
      if (pick < 70) it.count = COUNT_W'($urandom_range(0, 3));
      else if (pick < 97) it.count = COUNT_W'($urandom_range(4, 16));
      else it.count = COUNT_W'($urandom_range(17, 31));
      offer(it);
      finish_transfer(($urandom_range(0, 4) == 0) ? SLAVE_SLOW : SLAVE_ACKS, 1'b1);
   endtask

   task automatic write_csr(input logic [CSR_IDX_W-1:0] idx, input logic [CSR_DAT_W-1:0] val);
      @(posedge clock);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_data <= val;
      do @(posedge clock); while (!csr_ready);
      csr_valid <= 1'b0;
      if (idx == CSR_ACK_TIMEOUT) cfg_ack_timeout = val[TIMEOUT_W-1:0];
      else cfg_phase_ticks = val[PHASE_W-1:0];
   endtask

   task automatic set_bus_timing(input logic [15:0] ack_ticks, input logic [9:0] phase_len);
      write_csr(CSR_ACK_TIMEOUT, ack_ticks);
      write_csr(CSR_PHASE_TICKS, {6'd0, phase_len});
   endtask

   task automatic wait_drained();
      while (pending_req.size() != 0 || req_valid || expected_rsp.size() != 0)
         @(posedge clock);
      repeat (4) @(posedge clock);
   endtask

   task automatic run_phase(input logic [15:0] ack_ticks, input logic [9:0] phase_len,
                            input idle_kind_type style, input int budget, input bit squeeze);
      set_bus_timing(ack_ticks, phase_len);
      idle_style = style;
      useful_items = 0;
      while (useful_items < budget) random_transfer();
      // Park the receiver while the sender still has beats queued.
      if (squeeze) hold_asks++;
      wait_drained();
   endtask

   task automatic report_mismatch(input string what);
      mismatches++;
      $display("Mismatch on response beat %0d: %s", beats_checked, what);
   endtask

   task automatic check_field(input string name, input logic [7:0] got, input logic [7:0] want);
      if (got !== want) report_mismatch($sformatf("%s is %0h, expected %0h", name, got, want));
   endtask

   // Request driver.
   req_item_type req_cur;
   rsp_type      predicted;
   int           gap_left = 0;

   always @(posedge clock) begin
      if (reset) begin
         req_valid <= 1'b0;
      end else begin
         if (req_valid && req_ready) begin
            step_bus(live, req_cur, predicted);
            expected_rsp.push_back(predicted);
            beats_sent++;
         end
         if (!req_valid || req_ready) begin
            if (gap_left > 0) begin
               gap_left--;
               req_valid <= 1'b0;
            end else if (pending_req.size() != 0) begin
               req_cur = pending_req.pop_front();
               req_valid <= 1'b1;
               req_mode <= req_cur.mode;
               req_sda_in <= req_cur.sda;
               req_slave_addr <= req_cur.saddr;
               req_reg_addr <= req_cur.raddr;
               req_data_byte <= req_cur.data;
               req_byte_count <= req_cur.count;
               gap_left = idle_draw();
            end else begin
               req_valid <= 1'b0;
            end
         end
      end
   end

   // Long receiver hold, counted on its own.
   int   hold_left = 0;
   int   hold_seen = 0;
   logic hold_on = 1'b0;

   always @(posedge clock) begin
      if (hold_seen != hold_asks) begin
         hold_seen = hold_asks;
         hold_left = 80;
      end
      if (hold_left > 0) begin
         hold_left--;
         hold_on <= 1'b1;
      end else begin
         hold_on <= 1'b0;
      end
   end

   // Response monitor.
   rsp_type want_rsp;
   int      stall_left = 0;

   always @(posedge clock) begin
      if (reset) begin
         rsp_ready <= 1'b0;
      end else begin
         if (rsp_valid && rsp_ready) begin
            beats_checked++;
            if (expected_rsp.size() == 0) begin
               report_mismatch("response beat with nothing expected");
            end else begin
               want_rsp = expected_rsp.pop_front();
               check_field("scl_release", 8'(rsp_scl_release), 8'(want_rsp.scl_release));
               check_field("sda_release", 8'(rsp_sda_release), 8'(want_rsp.sda_release));
               check_field("busy_res", 8'(rsp_busy_res), 8'(want_rsp.busy_res));
               check_field("read_byte", rsp_read_byte, want_rsp.read_byte);
               check_field("read_valid", 8'(rsp_read_valid), 8'(want_rsp.read_valid));
               check_field("read_last", 8'(rsp_read_last), 8'(want_rsp.read_last));
               check_field("done_res", 8'(rsp_done_res), 8'(want_rsp.done_res));
               check_field("status", 8'(rsp_status), 8'(want_rsp.status));
               if (want_rsp.read_valid) bytes_read++;
               if (want_rsp.done_res) begin
                  transfers_done++;
                  if (want_rsp.status) timeouts_seen++;
               end
            end
            stall_left = idle_draw();
         end
         if (hold_on) begin
            rsp_ready <= 1'b0;
         end else if (stall_left > 0) begin
            stall_left--;
            rsp_ready <= 1'b0;
         end else begin
            rsp_ready <= 1'b1;
         end
      end
   end

   initial begin
      req_item_type it;
      live = fresh_model();
      plan = fresh_model();
      repeat (3) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Directed opening at the reset timing: idle tick, loads at the byte extremes,
      // a write asking for more bytes than are buffered, reads of zero and one byte,
      // and a write that asks for fewer bytes than are buffered.
      it = any_item(MODE_TICK);
      it.sda = 1'b1;
      offer(it);
      it = any_item(MODE_LOAD);
      it.data = 8'hFF;
      offer(it);
      it.data = 8'h00;
      offer(it);
      it.data = 8'hA5;
      offer(it);
      it = any_item(MODE_WRITE);
      it.saddr = 7'h7F;
      it.raddr = 8'hFF;
      it.count = 5'd31;
      offer(it);
      finish_transfer(SLAVE_ACKS, 1'b1);
      it = any_item(MODE_LOAD);
      it.data = 8'h3C;
      offer(it);
      offer(it);
      it = any_item(MODE_READ);
      it.saddr = 7'h00;
      it.raddr = 8'h00;
      it.count = 5'd0;
      offer(it);
      finish_transfer(SLAVE_ACKS, 1'b0);
      it = any_item(MODE_READ);
      it.saddr = 7'h55;
      it.raddr = 8'hAA;
      it.count = 5'd1;
      offer(it);
      finish_transfer(SLAVE_ACKS, 1'b1);
      it = any_item(MODE_WRITE);
      it.saddr = 7'h2A;
      it.raddr = 8'h0F;
      it.count = 5'd1;
      offer(it);
      finish_transfer(SLAVE_SLOW, 1'b0);
      wait_drained();

      run_phase(16'd3, 10'd1, IDLE_FULL, 120, 1'b1);
      run_phase(16'd1, 10'd2, IDLE_NONE, 90, 1'b0);
      run_phase(16'hFFFF, 10'd1, IDLE_LIGHT, 90, 1'b0);
      run_phase(16'd0, 10'd0, IDLE_FULL, 80, 1'b1);

      // Long bus phases: one transfer that gives up on the address ACK at the first high sample.
      set_bus_timing(16'd1, 10'd8);
      idle_style = IDLE_NONE;
      offer(any_item(MODE_WRITE));
      finish_transfer(SLAVE_ABSENT, 1'b0);
      wait_drained();

      run_phase(16'($urandom_range(2, 9)), 10'($urandom_range(2, 3)), IDLE_FULL, 100, 1'b1);
      run_phase(16'd6, 10'd1, IDLE_LIGHT, 110, 1'b0);
      repeat (8) @(posedge clock);

      $display("Sent %0d request beats and checked %0d response beats.", beats_sent,
               beats_checked);
      $display("Transfers finished: %0d (%0d on ACK timeout), bytes read back: %0d.",
               transfers_done, timeouts_seen, bytes_read);
      if (mismatches == 0) $display("*** PASSED ***");
      else $display("*** FAILED ***");
      $finish;
   end

   initial begin
      #(10_000_000);
      $display("Timed out with %0d beats still expected.", expected_rsp.size());
      $display("*** FAILED ***");
      $finish;
   end

endmodule
